// ===== src/jsf_pkg.sv =====
`timescale 1ns / 1ps
package jsf_pkg;

   localparam int LEN_W   = 16;
   localparam int CHUNK_W = 9;
   localparam int SLOTS   = 3;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BIT   = 1'b1;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_PAD    = 2'd2;

   typedef struct packed {
      logic             cmd;
      logic [LEN_W-1:0] seq_length;
      logic             raise_last_tms;
      logic             tdi_bit;
   } req_type;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic [1:0] byte_kind;
      logic       end_of_transfer;
   } result_type;

   // all words caused by one accepted request, oldest in slot 0
   typedef struct packed {
      logic [1:0]                  count;
      result_type [SLOTS-1:0]      slot;
   } bundle_type;

endpackage

// ===== src/jsf_if.sv =====
`timescale 1ns / 1ps
interface jsf_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [jsf_pkg::LEN_W-1:0]     seq_length;
   logic                          raise_last_tms;
   logic                          tdi_bit;

   modport source (output valid, cmd, seq_length, raise_last_tms, tdi_bit, input ready);
   modport sink (input valid, cmd, seq_length, raise_last_tms, tdi_bit, output ready);
endinterface

interface jsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] spi_byte;
   logic [1:0] byte_kind;
   logic       end_of_transfer;
   logic       last_of_run;

   modport source (output valid, spi_byte, byte_kind, end_of_transfer, last_of_run,
                   input ready);
   modport sink (input valid, spi_byte, byte_kind, end_of_transfer, last_of_run,
                 output ready);
endinterface

// ===== src/jsf_front.sv =====
`timescale 1ns / 1ps
module jsf_front #(
   parameter int CHUNK_SIZE = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  jsf_pkg::req_type     item,
   output logic                 push,
   output jsf_pkg::bundle_type  bundle
);
   import jsf_pkg::*;

   localparam logic [LEN_W-1:0] CHUNK_LEN = LEN_W'(CHUNK_SIZE);

   logic               active_ff, active_in;
   logic [LEN_W-1:0]   bits_ff, bits_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [1:0]         pair_ff, pair_in;
   logic [7:0]         acc_ff, acc_in;
   logic               raise_ff, raise_in;
   logic               pad_ff, pad_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         bits_ff   <= '0;
         chunk_ff  <= '0;
         pair_ff   <= '0;
         acc_ff    <= '0;
         raise_ff  <= 1'b0;
         pad_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         bits_ff   <= bits_in;
         chunk_ff  <= chunk_in;
         pair_ff   <= pair_in;
         acc_ff    <= acc_in;
         raise_ff  <= raise_in;
         pad_ff    <= pad_in;
      end
   end

   logic [LEN_W-1:0]   open_src;
   logic [LEN_W-1:0]   open_size;
   logic [LEN_W-1:0]   bits_dec;
   logic [CHUNK_W-1:0] chunk_dec;
   logic [1:0]         pair_val;
   logic [7:0]         acc_new;
   logic               tms;

   // shared chunk sizing for the start path and the chunk roll-over path
   always_comb begin
      open_src  = (item.cmd == CMD_START) ? item.seq_length : bits_dec;
      open_size = (open_src > CHUNK_LEN) ? CHUNK_LEN : open_src;
   end

   always_comb begin
      bits_dec  = bits_ff - 1'b1;
      chunk_dec = chunk_ff - 1'b1;
      tms       = raise_ff && (bits_ff == LEN_W'(1));
      pair_val  = {tms, item.tdi_bit};
      acc_new   = acc_ff | ({pair_val, 6'b0} >> {pair_ff, 1'b0});
   end

   logic [1:0] n;

   always_comb begin
      active_in = active_ff;
      bits_in   = bits_ff;
      chunk_in  = chunk_ff;
      pair_in   = pair_ff;
      acc_in    = acc_ff;
      raise_in  = raise_ff;
      pad_in    = pad_ff;
      bundle    = '0;
      n         = 2'd0;
      if (accept) begin
         if (item.cmd == CMD_START) begin
            active_in = 1'b0;
            bits_in   = '0;
            chunk_in  = '0;
            pair_in   = '0;
            acc_in    = '0;
            raise_in  = 1'b0;
            pad_in    = 1'b0;
            if (item.seq_length != '0) begin
               active_in = 1'b1;
               bits_in   = item.seq_length;
               raise_in  = item.raise_last_tms;
               pad_in    = (item.seq_length[1:0] == 2'b00);
               chunk_in  = open_size[CHUNK_W-1:0];
               bundle.slot[n] = '{spi_byte: open_size[7:0] - 8'd1,
                                  byte_kind: KIND_HEADER, end_of_transfer: 1'b0};
               n = n + 2'd1;
            end
         end else if (active_ff && chunk_ff != '0 && bits_ff != '0) begin
            bits_in  = bits_dec;
            chunk_in = chunk_dec;
            if (pair_ff == 2'd3 || chunk_dec == '0) begin
               bundle.slot[n] = '{spi_byte: acc_new, byte_kind: KIND_DATA,
                                  end_of_transfer: (chunk_dec == '0) && !pad_ff};
               n       = n + 2'd1;
               acc_in  = '0;
               pair_in = '0;
            end else begin
               acc_in  = acc_new;
               pair_in = pair_ff + 2'd1;
            end
            if (chunk_dec == '0) begin
               if (pad_ff) begin
                  bundle.slot[n] = '{spi_byte: 8'd0, byte_kind: KIND_PAD,
                                     end_of_transfer: 1'b1};
                  n = n + 2'd1;
               end
               if (bits_dec != '0) begin
                  chunk_in = open_size[CHUNK_W-1:0];
                  pair_in  = '0;
                  acc_in   = '0;
                  bundle.slot[n] = '{spi_byte: open_size[7:0] - 8'd1,
                                     byte_kind: KIND_HEADER, end_of_transfer: 1'b0};
                  n = n + 2'd1;
               end else begin
                  active_in = 1'b0;
                  bits_in   = '0;
                  chunk_in  = '0;
                  pair_in   = '0;
                  acc_in    = '0;
                  raise_in  = 1'b0;
                  pad_in    = 1'b0;
               end
            end
         end
      end
      bundle.count = n;
      push         = (n != 2'd0);
   end

endmodule

// ===== src/jsf_queue.sv =====
`timescale 1ns / 1ps
module jsf_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  jsf_pkg::bundle_type  push_data,
   input  logic                 pop,
   output jsf_pkg::bundle_type  head,
   output logic                 empty,
   output logic                 full
);
   import jsf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   bundle_type         mem [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      wr_in    = push ? ((wr_ff == LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = pop ? ((rd_ff == LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head  = mem[rd_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count out of range");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && pop) |=> $stable(count_ff))
      else $error("queue count moved on simultaneous push and pop");

endmodule

// ===== src/jsf_back.sv =====
`timescale 1ns / 1ps
module jsf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  jsf_pkg::bundle_type  head,
   input  logic                 empty,
   output logic                 pop,
   input  logic                 out_ready,
   output logic                 out_valid,
   output jsf_pkg::result_type  out_result,
   output logic                 out_last
);
   import jsf_pkg::*;

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   result_type result_ff;
   logic       last_ff;
   logic       load;
   logic       at_end;

   always_comb begin
      load     = !empty && (!valid_ff || out_ready);
      at_end   = (idx_ff == head.count - 2'd1);
      pop      = load && at_end;
      idx_in   = load ? (at_end ? 2'd0 : idx_ff + 2'd1) : idx_ff;
      valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= head.slot[idx_ff];
         last_ff   <= at_end;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;
   assign out_last   = last_ff;

endmodule

// ===== src/jtag_shift_spi_framer_unit.sv =====
`timescale 1ns / 1ps
// channel   dir  word contents
// req_if    in   cmd, seq_length, raise_last_tms, tdi_bit
// rsp_if    out  spi_byte, byte_kind, end_of_transfer, last_of_run
//
// one request word per cycle; the front end updates the sequence state and
// emits all of that word's results (up to three) as one bundle in the same cycle
// the back end sends one response word per ready cycle from its output register
// req_ready drops only when the bundle queue (QUEUE_DEPTH entries) is full
// synchronous active-high reset empties the queue and clears the sequence state
module jtag_shift_spi_framer_unit #(
   parameter int CHUNK_SIZE  = 256,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   jsf_req_if.sink      req_if,
   jsf_rsp_if.source    rsp_if
);
   import jsf_pkg::*;

   req_type    item;
   bundle_type push_bundle;
   bundle_type head;
   result_type out_result;
   logic       accept;
   logic       push;
   logic       pop;
   logic       empty;
   logic       full;

   // request word is taken whenever the queue has a free bundle slot
   assign req_if.ready = !full;
   assign accept       = req_if.valid && !full;

   assign item = '{cmd: req_if.cmd, seq_length: req_if.seq_length,
                   raise_last_tms: req_if.raise_last_tms, tdi_bit: req_if.tdi_bit};

   // front end: sequence tracking, byte packing and chunk framing
   jsf_front #(
      .CHUNK_SIZE (CHUNK_SIZE)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .push   (push),
      .bundle (push_bundle)
   );

   // decouples the front end from a stalled response side
   jsf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_bundle),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   // back end: unpacks each bundle into single response words
   jsf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .out_ready  (rsp_if.ready),
      .out_valid  (rsp_if.valid),
      .out_result (out_result),
      .out_last   (rsp_if.last_of_run)
   );

   assign rsp_if.spi_byte        = out_result.spi_byte;
   assign rsp_if.byte_kind       = out_result.byte_kind;
   assign rsp_if.end_of_transfer = out_result.end_of_transfer;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;

   localparam int CHUNK_LEN    = 256;
   localparam int RANDOM_ITEMS = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 30;

   // one spi word as the block hands it out
   typedef struct packed {
      logic [7:0] spi_byte;
      logic [1:0] byte_kind;
      logic       end_of_transfer;
      logic       last_of_run;
   } spi_word_type;

   logic clock;
   logic reset;

   jsf_req_if req_if ();
   jsf_rsp_if rsp_if ();

   jtag_shift_spi_framer_unit #(
      .CHUNK_SIZE (CHUNK_LEN)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // request words still to be offered, oldest first
   jsf_pkg::req_type pending_words[$];
   // spi words the framer owes us, oldest first
   spi_word_type framed_bytes_due[$];

   // framer state as we predict it
   logic        seq_active;
   logic [15:0] bits_to_go;
   logic [8:0]  chunk_left;
   int          pair_pos;
   logic [7:0]  tdi_acc;
   logic        tms_at_end;
   logic        pad_chunks;

   // bookkeeping
   int errors;
   int reports;
   int random_items;
   int requests_taken;
   int words_checked;
   int sequences_started;
   int chunk_headers;
   int pad_bytes;
   int burst_left;
   int gap_left;
   int quiet_cycles;
   int hold_left;
   logic held_off;
   logic [15:0] rx_cycle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------

   task automatic clear_sequence();
      seq_active = 1'b0;
      bits_to_go = '0;
      chunk_left = '0;
      pair_pos   = 0;
      tdi_acc    = '0;
      tms_at_end = 1'b0;
      pad_chunks = 1'b0;
   endtask

   // starts the next chunk and returns its header byte (chunk size minus one)
   function automatic logic [7:0] open_chunk();
      int size;
      size       = (bits_to_go > CHUNK_LEN) ? CHUNK_LEN : int'(bits_to_go);
      chunk_left = 9'(size);
      pair_pos   = 0;
      tdi_acc    = '0;
      chunk_headers++;
      return 8'(size - 1);
   endfunction

   // works out every spi word caused by one accepted request word
   task automatic frame_request(input jsf_pkg::req_type w);
      spi_word_type caused[jsf_pkg::SLOTS];
      int           n;
      logic [1:0]   pair;
      n = 0;
      if (w.cmd == jsf_pkg::CMD_START) begin
         // a new start always drops whatever was in flight
         clear_sequence();
         if (w.seq_length != '0) begin
            seq_active = 1'b1;
            bits_to_go = w.seq_length;
            tms_at_end = w.raise_last_tms;
            // lengths that are a multiple of four get a pad byte per chunk
            pad_chunks = (w.seq_length[1:0] == 2'b00);
            sequences_started++;
            caused[n] = '{open_chunk(), jsf_pkg::KIND_HEADER, 1'b0, 1'b0};
            n++;
         end
      end else if (seq_active && chunk_left != '0 && bits_to_go != '0) begin
         // tms only rises on the very last bit, and only if asked for
         pair       = {tms_at_end && bits_to_go == 16'd1, w.tdi_bit};
         tdi_acc    = tdi_acc | ({6'd0, pair} << (6 - 2 * pair_pos));
         pair_pos   = pair_pos + 1;
         chunk_left = chunk_left - 9'd1;
         bits_to_go = bits_to_go - 16'd1;
         if (pair_pos == 4 || chunk_left == '0) begin
            caused[n] = '{tdi_acc, jsf_pkg::KIND_DATA, chunk_left == '0 && !pad_chunks, 1'b0};
            n++;
            tdi_acc  = '0;
            pair_pos = 0;
         end
         if (chunk_left == '0) begin
            if (pad_chunks) begin
               caused[n] = '{8'd0, jsf_pkg::KIND_PAD, 1'b1, 1'b0};
               n++;
               pad_bytes++;
            end
            if (bits_to_go != '0) begin
               caused[n] = '{open_chunk(), jsf_pkg::KIND_HEADER, 1'b0, 1'b0};
               n++;
            end else begin
               clear_sequence();
            end
         end
      end
      // the last word of the run carries the marker
      for (int i = 0; i < n; i++) begin
         caused[i].last_of_run = (i == n - 1);
         framed_bytes_due.push_back(caused[i]);
      end
   endtask

   // ---------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------

   // a start word; the bit field is left random since it is not read
   task automatic push_start(input int len, input logic ftms);
      jsf_pkg::req_type w;
      w.cmd            = jsf_pkg::CMD_START;
      w.seq_length     = 16'(len);
      w.raise_last_tms = ftms;
      w.tdi_bit        = 1'($urandom_range(0, 1));
      pending_words.push_back(w);
   endtask

   // a bit word; length and flag fields are random as they are not read
   task automatic push_bit(input logic tdi);
      jsf_pkg::req_type w;
      w.cmd            = jsf_pkg::CMD_BIT;
      w.seq_length     = 16'($urandom_range(0, 65535));
      w.raise_last_tms = 1'($urandom_range(0, 1));
      w.tdi_bit        = tdi;
      pending_words.push_back(w);
   endtask

   // a start followed by nbits random tdi bits; nbits below len leaves it open
   task automatic queue_sequence(input int len, input logic ftms, input int nbits);
      push_start(len, ftms);
      for (int i = 0; i < nbits; i++)
         push_bit(1'($urandom_range(0, 1)));
      random_items += nbits + 1;
   endtask

   // ---------------------------------------------------------------
   // request driver: bursts of random length with random gaps
   // ---------------------------------------------------------------

   always @(posedge clock) begin : req_driver
      logic took;
      logic offer;
      took = req_if.valid && req_if.ready;
      if (reset) begin
         req_if.valid          <= 1'b0;
         req_if.cmd            <= jsf_pkg::CMD_START;
         req_if.seq_length     <= '0;
         req_if.raise_last_tms <= 1'b0;
         req_if.tdi_bit        <= 1'b0;
      end else begin
         if (took)
            void'(pending_words.pop_front());
         // a word not yet taken stays on the bus unchanged
         offer = req_if.valid && !took;
         if (!offer && pending_words.size() > 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               offer = 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 20);
                  // a quarter of bursts run straight into the next one
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
         req_if.valid <= offer;
         if (offer) begin
            req_if.cmd            <= pending_words[0].cmd;
            req_if.seq_length     <= pending_words[0].seq_length;
            req_if.raise_last_tms <= pending_words[0].raise_last_tms;
            req_if.tdi_bit        <= pending_words[0].tdi_bit;
         end
      end
   end

   // ---------------------------------------------------------------
   // response pacing: a rotating stall pattern plus one long hold-off
   // ---------------------------------------------------------------

   always @(posedge clock) begin : rsp_pacing
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rx_cycle     <= '0;
         hold_left    <= 0;
         held_off     <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 16'd1;
         if (hold_left > 0) begin
            // long hold-off so the output queue fills and req_ready drops
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
         end else if (!held_off && requests_taken >= 150) begin
            held_off     <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else if (rx_cycle[8:7] == 2'b00) begin
            // always ready stretch
            rsp_if.ready <= 1'b1;
         end else if (rx_cycle[8:7] == 2'b01) begin
            // regular stall pattern taken from the cycle counter
            rsp_if.ready <= (rx_cycle % 16'd5) != 16'd3;
         end else if (rx_cycle[8:7] == 2'b10) begin
            rsp_if.ready <= $urandom_range(0, 3) != 0;
         end else begin
            rsp_if.ready <= 1'($urandom_range(0, 1));
         end
      end
   end

   // ---------------------------------------------------------------
   // scoreboard: predict on each accepted request, check each response
   // ---------------------------------------------------------------

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         errors++;
         reports++;
         if (reports <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      jsf_pkg::req_type w;
      spi_word_type     got;
      spi_word_type     want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            w.cmd            = req_if.cmd;
            w.seq_length     = req_if.seq_length;
            w.raise_last_tms = req_if.raise_last_tms;
            w.tdi_bit        = req_if.tdi_bit;
            frame_request(w);
            requests_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.spi_byte, rsp_if.byte_kind, rsp_if.end_of_transfer,
                   rsp_if.last_of_run};
            words_checked++;
            if (framed_bytes_due.size() == 0) begin
               errors++;
               reports++;
               if (reports <= MAX_REPORTS)
                  $display("%0t: unexpected word, expected none, got %h", $time, got);
            end else begin
               want = framed_bytes_due.pop_front();
               check_field("spi_byte", want.spi_byte, got.spi_byte);
               check_field("byte_kind", 8'(want.byte_kind), 8'(got.byte_kind));
               check_field("end_of_transfer", 8'(want.end_of_transfer),
                           8'(got.end_of_transfer));
               check_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // watchdog: too long with nothing moving on either channel
   // ---------------------------------------------------------------

   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL jtag_shift_spi_framer_unit");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------

   initial begin
      req_if.valid          = 1'b0;
      req_if.cmd            = jsf_pkg::CMD_START;
      req_if.seq_length     = '0;
      req_if.raise_last_tms = 1'b0;
      req_if.tdi_bit        = 1'b0;
      rsp_if.ready          = 1'b0;
      reset                 = 1'b1;
      errors                = 0;
      reports               = 0;
      random_items          = 0;
      requests_taken        = 0;
      words_checked         = 0;
      sequences_started     = 0;
      chunk_headers         = 0;
      pad_bytes             = 0;
      burst_left            = 0;
      gap_left              = 0;
      quiet_cycles          = 0;
      clear_sequence();

      // directed part
      push_bit(1'b1);               // bit word with no sequence open: ignored
      push_start(0, 1'b1);          // zero length start: nothing comes out
      queue_sequence(4, 1'b1, 4);   // full byte, tms on last bit, pad byte
      queue_sequence(5, 1'b0, 2);   // left half done, dropped by next start
      queue_sequence(3, 1'b1, 3);   // partial last byte with a zeroed low pair
      queue_sequence(1, 1'b1, 1);   // shortest sequence
      push_start(16'hFFFF, 1'b1);   // longest length, full size header
      push_bit(1'b1);
      push_start(0, 1'b0);          // zero length start closes the open sequence
      push_bit(1'b0);               // ignored again

      // one padded sequence that crosses a chunk boundary
      queue_sequence(CHUNK_LEN + 4, 1'($urandom_range(0, 1)), CHUNK_LEN + 4);

      // random part: short sequences, broken ones, stray bits and empty starts
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         int pick;
         int len;
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            push_start(0, 1'($urandom_range(0, 1)));
            random_items++;
         end else if (pick == 1) begin
            // stray bits, mostly landing on an idle framer
            push_bit(1'($urandom_range(0, 1)));
         end else if (pick <= 4) begin
            // broken sequence: cut short, often with a huge length
            len = ($urandom_range(0, 1) == 1) ? $urandom_range(2, 65535)
                                              : $urandom_range(2, 40);
            queue_sequence(len, 1'($urandom_range(0, 1)), $urandom_range(1, 12));
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                              : $urandom_range(1, 24);
            queue_sequence(len, 1'($urandom_range(0, 1)), len);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // all requests taken, then all owed words in, then a short quiet spell
      while (pending_words.size() != 0) @(negedge clock);
      while (framed_bytes_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run covered %0d request words and %0d spi words checked",
               requests_taken, words_checked);
      $display("%0d sequences started, %0d chunk headers, %0d pad bytes, long hold-off %0s",
               sequences_started, chunk_headers, pad_bytes, held_off ? "done" : "missed");
      if (errors == 0 && framed_bytes_due.size() == 0) begin
         $display("PASS jtag_shift_spi_framer_unit");
      end else begin
         $display("%0d errors, %0d words still owed", errors, framed_bytes_due.size());
         $display("FAIL jtag_shift_spi_framer_unit");
      end
      $finish;
   end

endmodule
